// ===== rtl/core/pinv_pkg.sv =====
// shared constants for the pose inverter and path length unit
`default_nettype none
package pinv_pkg;

   localparam int QUAT_WIDTH_DEF = 16;
   localparam int POS_WIDTH_DEF  = 32;
   localparam int DIST_WIDTH_DEF = 48;

   // sequence index width is fixed by the result word
   localparam int CNT_W = 32;

   // words held between front and back
   localparam int QUEUE_DEPTH = 2;

   // multiply-accumulate program of the back end
   localparam int NUM_OPS          = 18;
   localparam int STEP_W           = 5;
   localparam int LAST_OP_NO_DIST  = 14;

endpackage
`default_nettype wire

// ===== rtl/core/pose_invert_path_length_unit.sv =====
// top level: inverts camera poses and accumulates trajectory path length
// the first pose of a trajectory takes 15 passes through the one shared multiplier;
// other poses take 18 multiplier passes plus the square root that yields one bit per cycle
// the back end takes no new word until its result is loaded into the output register,
// which rsp_stall can hold off;
// the two-word queue lets the front keep taking words meanwhile
// reset: synchronous; clears the queue, trajectory index, path length and output valid
`default_nettype none
module pose_invert_path_length_unit #(
   parameter int QUAT_WIDTH = pinv_pkg::QUAT_WIDTH_DEF,
   parameter int POS_WIDTH  = pinv_pkg::POS_WIDTH_DEF,
   parameter int DIST_WIDTH = pinv_pkg::DIST_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_start_req,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_w,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_x,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_y,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_z,
   input  wire signed [POS_WIDTH-1:0]   req_trans_x,
   input  wire signed [POS_WIDTH-1:0]   req_trans_y,
   input  wire signed [POS_WIDTH-1:0]   req_trans_z,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [QUAT_WIDTH-1:0] rsp_rot_x,
   output logic signed [QUAT_WIDTH-1:0] rsp_rot_y,
   output logic signed [QUAT_WIDTH-1:0] rsp_rot_z,
   output logic signed [QUAT_WIDTH-1:0] rsp_rot_w,
   output logic signed [POS_WIDTH-1:0]  rsp_pos_x,
   output logic signed [POS_WIDTH-1:0]  rsp_pos_y,
   output logic signed [POS_WIDTH-1:0]  rsp_pos_z,
   output logic [pinv_pkg::CNT_W-1:0]   rsp_seq_index,
   output logic [DIST_WIDTH-1:0]        rsp_path_length
);
   import pinv_pkg::*;

   localparam int ITEM_W = 1 + 4 * QUAT_WIDTH + 3 * (POS_WIDTH + 1);

   logic              push_valid, push_stall, pop_valid, pop_ready;
   logic [ITEM_W-1:0] push_data, pop_data;

   pinv_front #(
      .QUAT_WIDTH(QUAT_WIDTH),
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_start_req(req_start_req),
      .req_quat_w   (req_quat_w),
      .req_quat_x   (req_quat_x),
      .req_quat_y   (req_quat_y),
      .req_quat_z   (req_quat_z),
      .req_trans_x  (req_trans_x),
      .req_trans_y  (req_trans_y),
      .req_trans_z  (req_trans_z),
      .push_valid   (push_valid),
      .push_stall   (push_stall),
      .push_data    (push_data)
   );

   pinv_queue #(
      .DATA_W(ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_stall(push_stall),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   pinv_back #(
      .QUAT_WIDTH(QUAT_WIDTH),
      .POS_WIDTH (POS_WIDTH),
      .DIST_WIDTH(DIST_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rot_x      (rsp_rot_x),
      .rsp_rot_y      (rsp_rot_y),
      .rsp_rot_z      (rsp_rot_z),
      .rsp_rot_w      (rsp_rot_w),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_pos_z      (rsp_pos_z),
      .rsp_seq_index  (rsp_seq_index),
      .rsp_path_length(rsp_path_length)
   );

endmodule
`default_nettype wire

// ===== rtl/core/pinv_front.sv =====
// front end: takes request words, conjugates the quaternion and negates the translation
`default_nettype none
module pinv_front #(
   parameter int QUAT_WIDTH = pinv_pkg::QUAT_WIDTH_DEF,
   parameter int POS_WIDTH  = pinv_pkg::POS_WIDTH_DEF
) (
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_start_req,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_w,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_x,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_y,
   input  wire signed [QUAT_WIDTH-1:0]  req_quat_z,
   input  wire signed [POS_WIDTH-1:0]   req_trans_x,
   input  wire signed [POS_WIDTH-1:0]   req_trans_y,
   input  wire signed [POS_WIDTH-1:0]   req_trans_z,
   output logic                         push_valid,
   input  wire                          push_stall,
   output logic [1+4*QUAT_WIDTH+3*(POS_WIDTH+1)-1:0] push_data
);
   localparam int QW  = QUAT_WIDTH;
   localparam int V_W = POS_WIDTH + 1;
   localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
   localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};

   logic signed [QW-1:0]  u_x, u_y, u_z;
   logic signed [V_W-1:0] v_x, v_y, v_z;

   function automatic logic signed [QW-1:0] neg_sat(input logic signed [QW-1:0] q);
      logic signed [QW-1:0] r;
      begin
         if (q == QMIN) begin
            r = QMAX;
         end else begin
            r = -q;
         end
         return r;
      end
   endfunction

   always_comb begin
      u_x = neg_sat(req_quat_x);
      u_y = neg_sat(req_quat_y);
      u_z = neg_sat(req_quat_z);
      // one extra bit so the negated minimum fits
      v_x = -V_W'(req_trans_x);
      v_y = -V_W'(req_trans_y);
      v_z = -V_W'(req_trans_z);
   end

   assign push_valid = req_valid;
   assign req_stall  = push_stall;
   assign push_data  = {req_start_req, req_quat_w, u_x, u_y, u_z, v_x, v_y, v_z};

endmodule
`default_nettype wire

// ===== rtl/core/pinv_queue.sv =====
// small word queue between front and back end
`default_nettype none
module pinv_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = pinv_pkg::QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_stall,
   input  wire  [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  wire               pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              push_go, pop_go;

   assign push_stall = (cnt_ff == CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_go    = push_valid && !push_stall;
   assign pop_go     = pop_ready && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_go) begin
            mem_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_go) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_go && !pop_go) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop_go && !push_go) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/pinv_back.sv =====
// back end: shared multiplier program, bit-serial square root, trajectory state
`default_nettype none
module pinv_back #(
   parameter int QUAT_WIDTH = pinv_pkg::QUAT_WIDTH_DEF,
   parameter int POS_WIDTH  = pinv_pkg::POS_WIDTH_DEF,
   parameter int DIST_WIDTH = pinv_pkg::DIST_WIDTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             pop_valid,
   output logic                            pop_ready,
   input  wire  [1+4*QUAT_WIDTH+3*(POS_WIDTH+1)-1:0] pop_data,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic signed [QUAT_WIDTH-1:0]    rsp_rot_x,
   output logic signed [QUAT_WIDTH-1:0]    rsp_rot_y,
   output logic signed [QUAT_WIDTH-1:0]    rsp_rot_z,
   output logic signed [QUAT_WIDTH-1:0]    rsp_rot_w,
   output logic signed [POS_WIDTH-1:0]     rsp_pos_x,
   output logic signed [POS_WIDTH-1:0]     rsp_pos_y,
   output logic signed [POS_WIDTH-1:0]     rsp_pos_z,
   output logic [pinv_pkg::CNT_W-1:0]      rsp_seq_index,
   output logic [DIST_WIDTH-1:0]           rsp_path_length
);
   import pinv_pkg::*;

   localparam int QW     = QUAT_WIDTH;
   localparam int PW     = POS_WIDTH;
   localparam int DW     = DIST_WIDTH;
   localparam int QFRAC  = QW - 2;
   localparam int V_W    = PW + 1;
   localparam int T_W    = PW + 5;
   localparam int MA_W   = T_W;
   localparam int MB_W   = (QW > PW + 2) ? QW : PW + 2;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = (QW + PW + 8 > PROD_W) ? QW + PW + 8 : PROD_W;
   localparam int SQ_W   = PW + 2;
   localparam int N_W    = 2 * SQ_W;
   localparam int REM_W  = SQ_W + 3;
   localparam int IT_W   = $clog2(SQ_W);
   localparam int SUM_W  = ((DW > SQ_W) ? DW : SQ_W) + 1;

   localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
   localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(1) << (QFRAC - 1);
   localparam logic signed [ACC_W-1:0] PMAX_A   = (ACC_W'(1) << (PW - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] PMIN_A   = -PMAX_A - ACC_W'(1);
   localparam logic [DW-1:0]           DMAX     = '1;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_DRAIN, S_SQRT, S_DONE} state_type;
   typedef enum logic [3:0] {A_V0, A_V1, A_V2, A_T0, A_T1, A_T2, A_D0, A_D1, A_D2} asel_type;
   typedef enum logic [2:0] {B_U0, B_U1, B_U2, B_W, B_D0, B_D1, B_D2} bsel_type;
   typedef enum logic [2:0] {
      DST_NONE, DST_T0, DST_T1, DST_T2, DST_P0, DST_P1, DST_P2, DST_SUM
   } dst_type;
   typedef struct packed {
      asel_type asel;
      bsel_type bsel;
      logic     clr;
      logic     neg;
      dst_type  dst;
   } op_type;

   function automatic op_type mk_op(input asel_type a, input bsel_type b,
                                    input logic c, input logic n, input dst_type d);
      op_type o;
      begin
         o.asel = a;
         o.bsel = b;
         o.clr  = c;
         o.neg  = n;
         o.dst  = d;
         return o;
      end
   endfunction

   // T = 2*cross(u,v), then w*T + cross(u,T), then squared differences
   function automatic op_type op_decode(input logic [STEP_W-1:0] s);
      op_type o;
      begin
         unique case (s)
            5'd0:    o = mk_op(A_V2, B_U1, 1'b1, 1'b0, DST_NONE);
            5'd1:    o = mk_op(A_V1, B_U2, 1'b0, 1'b1, DST_T0);
            5'd2:    o = mk_op(A_V0, B_U2, 1'b1, 1'b0, DST_NONE);
            5'd3:    o = mk_op(A_V2, B_U0, 1'b0, 1'b1, DST_T1);
            5'd4:    o = mk_op(A_V1, B_U0, 1'b1, 1'b0, DST_NONE);
            5'd5:    o = mk_op(A_V0, B_U1, 1'b0, 1'b1, DST_T2);
            5'd6:    o = mk_op(A_T0, B_W,  1'b1, 1'b0, DST_NONE);
            5'd7:    o = mk_op(A_T2, B_U1, 1'b0, 1'b0, DST_NONE);
            5'd8:    o = mk_op(A_T1, B_U2, 1'b0, 1'b1, DST_P0);
            5'd9:    o = mk_op(A_T1, B_W,  1'b1, 1'b0, DST_NONE);
            5'd10:   o = mk_op(A_T0, B_U2, 1'b0, 1'b0, DST_NONE);
            5'd11:   o = mk_op(A_T2, B_U0, 1'b0, 1'b1, DST_P1);
            5'd12:   o = mk_op(A_T2, B_W,  1'b1, 1'b0, DST_NONE);
            5'd13:   o = mk_op(A_T1, B_U0, 1'b0, 1'b0, DST_NONE);
            5'd14:   o = mk_op(A_T0, B_U1, 1'b0, 1'b1, DST_P2);
            5'd15:   o = mk_op(A_D0, B_D0, 1'b1, 1'b0, DST_NONE);
            5'd16:   o = mk_op(A_D1, B_D1, 1'b0, 1'b0, DST_NONE);
            5'd17:   o = mk_op(A_D2, B_D2, 1'b0, 1'b0, DST_SUM);
            default: o = mk_op(A_V0, B_U0, 1'b1, 1'b0, DST_NONE);
         endcase
         return o;
      end
   endfunction

   state_type              state_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   start_in;
   logic signed [QW-1:0]   w_ff;
   logic signed [QW-1:0]   u_ff [3];
   logic signed [V_W-1:0]  v_ff [3];
   logic signed [T_W-1:0]  t_ff [3];
   logic signed [PW-1:0]   p_ff [3];
   logic signed [PW-1:0]   prev_ff [3];
   logic                   has_prev_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [DW-1:0]          sum_ff;

   op_type                 op, ctl_ff;
   logic                   ctl_vld_ff;
   logic signed [MA_W-1:0] ma;
   logic signed [MB_W-1:0] mb;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_add, acc_base;
   logic signed [ACC_W-1:0]  acc_dbl, t_sum, t_rnd, p_sum0, p_rnd, p_sum;
   logic signed [T_W-1:0]    t_in;
   logic signed [PW-1:0]     p_in;
   logic signed [V_W-1:0]    v_sel;
   logic signed [V_W-1:0]    pd [3];
   logic [V_W-1:0]           d [3];
   logic [STEP_W-1:0]        last_step;

   logic [N_W-1:0]   n_ff;
   logic [REM_W-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [SQ_W-1:0]  root_ff, root_in, seg;
   logic [IT_W-1:0]  it_ff;
   logic [SUM_W-1:0] tot;
   logic [DW-1:0]    sum_in;
   logic [CNT_W-1:0] cnt_in;

   logic signed [QW-1:0] in_w, in_u0, in_u1, in_u2;
   logic signed [V_W-1:0] in_v0, in_v1, in_v2;

   assign {start_in, in_w, in_u0, in_u1, in_u2, in_v0, in_v1, in_v2} = pop_data;
   assign pop_ready = (state_ff == S_IDLE);
   assign op        = op_decode(step_ff);
   assign last_step = has_prev_ff ? STEP_W'(NUM_OPS - 1) : STEP_W'(LAST_OP_NO_DIST);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd[i] = V_W'(p_ff[i]) - V_W'(prev_ff[i]);
         d[i]  = (pd[i] < 0) ? V_W'(-pd[i]) : V_W'(pd[i]);
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (op.asel)
         A_V0:    ma = MA_W'(v_ff[0]);
         A_V1:    ma = MA_W'(v_ff[1]);
         A_V2:    ma = MA_W'(v_ff[2]);
         A_T0:    ma = t_ff[0];
         A_T1:    ma = t_ff[1];
         A_T2:    ma = t_ff[2];
         A_D0:    ma = MA_W'($signed({1'b0, d[0]}));
         A_D1:    ma = MA_W'($signed({1'b0, d[1]}));
         A_D2:    ma = MA_W'($signed({1'b0, d[2]}));
         default: ma = '0;
      endcase
      unique case (op.bsel)
         B_U0:    mb = MB_W'(u_ff[0]);
         B_U1:    mb = MB_W'(u_ff[1]);
         B_U2:    mb = MB_W'(u_ff[2]);
         B_W:     mb = MB_W'(w_ff);
         B_D0:    mb = MB_W'($signed({1'b0, d[0]}));
         B_D1:    mb = MB_W'($signed({1'b0, d[1]}));
         B_D2:    mb = MB_W'($signed({1'b0, d[2]}));
         default: mb = '0;
      endcase
   end

   // accumulate the registered product and round at the end of each term
   always_comb begin
      acc_add  = ctl_ff.neg ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
      acc_base = ctl_ff.clr ? ACC_ZERO : acc_ff;
      acc_in   = acc_base + acc_add;
      acc_dbl  = acc_in <<< 1;
      t_sum    = acc_dbl + HALF;
      t_rnd    = t_sum >>> QFRAC;
      t_in     = T_W'(t_rnd);
      unique case (ctl_ff.dst)
         DST_P0:  v_sel = v_ff[0];
         DST_P1:  v_sel = v_ff[1];
         default: v_sel = v_ff[2];
      endcase
      p_sum0 = acc_in + HALF;
      p_rnd  = p_sum0 >>> QFRAC;
      p_sum  = p_rnd + ACC_W'(v_sel);
      if (p_sum > PMAX_A) begin
         p_in = PMAX_A[PW-1:0];
      end else if (p_sum < PMIN_A) begin
         p_in = PMIN_A[PW-1:0];
      end else begin
         p_in = p_sum[PW-1:0];
      end
   end

   // one root bit per cycle
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], n_ff[N_W-1 -: 2]};
      trial  = REM_W'({root_ff, 2'b01});
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[SQ_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[SQ_W-2:0], 1'b0};
      end
   end

   always_comb begin
      seg    = has_prev_ff ? root_ff : '0;
      tot    = SUM_W'(sum_ff) + SUM_W'(seg);
      sum_in = (tot > SUM_W'(DMAX)) ? DMAX : DW'(tot);
      cnt_in = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ctl_vld_ff  <= 1'b0;
         has_prev_ff <= 1'b0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         rsp_valid   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         if (state_ff == S_DONE && (!rsp_valid || !rsp_stall)) begin
            rsp_valid <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         ctl_vld_ff <= (state_ff == S_MUL);
         ctl_ff     <= op;
         prod_ff    <= ma * mb;
         if (ctl_vld_ff) begin
            acc_ff <= acc_in;
            unique case (ctl_ff.dst)
               DST_T0:  t_ff[0] <= t_in;
               DST_T1:  t_ff[1] <= t_in;
               DST_T2:  t_ff[2] <= t_in;
               DST_P0:  p_ff[0] <= p_in;
               DST_P1:  p_ff[1] <= p_in;
               DST_P2:  p_ff[2] <= p_in;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  w_ff    <= in_w;
                  u_ff[0] <= in_u0;
                  u_ff[1] <= in_u1;
                  u_ff[2] <= in_u2;
                  v_ff[0] <= in_v0;
                  v_ff[1] <= in_v1;
                  v_ff[2] <= in_v2;
                  if (start_in) begin
                     has_prev_ff <= 1'b0;
                     cnt_ff      <= '0;
                     sum_ff      <= '0;
                  end
                  step_ff  <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == last_step) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (has_prev_ff) begin
                  n_ff     <= N_W'(acc_in);
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  it_ff    <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SQRT: begin
               n_ff    <= n_ff << 2;
               rem_ff  <= rem_in;
               root_ff <= root_in;
               it_ff   <= it_ff + 1'b1;
               if (it_ff == IT_W'(SQ_W - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_rot_x       <= u_ff[0];
                  rsp_rot_y       <= u_ff[1];
                  rsp_rot_z       <= u_ff[2];
                  rsp_rot_w       <= w_ff;
                  rsp_pos_x       <= p_ff[0];
                  rsp_pos_y       <= p_ff[1];
                  rsp_pos_z       <= p_ff[2];
                  rsp_seq_index   <= cnt_ff;
                  rsp_path_length <= sum_in;
                  sum_ff          <= sum_in;
                  cnt_ff          <= cnt_in;
                  has_prev_ff     <= 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     prev_ff[i] <= p_ff[i];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/pinv_checker.sv =====
// port-level checks for the pose inverter, bound to the top level
`default_nettype none
module pinv_checker #(
   parameter int QUAT_WIDTH = pinv_pkg::QUAT_WIDTH_DEF,
   parameter int DIST_WIDTH = pinv_pkg::DIST_WIDTH_DEF
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [QUAT_WIDTH-1:0]         rsp_rot_x,
   input wire [pinv_pkg::CNT_W-1:0]    rsp_seq_index,
   input wire [DIST_WIDTH-1:0]         rsp_path_length
);
   localparam logic [QUAT_WIDTH-1:0] QMIN = {1'b1, {(QUAT_WIDTH-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_index == '0 |-> rsp_path_length == '0)
      else $error("first pose of trajectory carries distance");

   a_rot_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rot_x != QMIN)
      else $error("negated rotation not saturated");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pose_invert_path_length_unit pinv_checker #(
   .QUAT_WIDTH(QUAT_WIDTH),
   .DIST_WIDTH(DIST_WIDTH)
) u_pinv_checker (.*);
`default_nettype wire

// ===== tb/pose_invert_path_length_unit_test.sv =====
// self-checking bench for the pose inverter and path length unit
`default_nettype none
module pose_invert_path_length_unit_test;

   localparam int QW = pinv_pkg::QUAT_WIDTH_DEF;
   localparam int PW = pinv_pkg::POS_WIDTH_DEF;
   localparam int DW = pinv_pkg::DIST_WIDTH_DEF;
   localparam int QFRAC = QW - 2;
   localparam longint QMAX = (64'sd1 <<< (QW - 1)) - 1;
   localparam longint QMIN = -(64'sd1 <<< (QW - 1));
   localparam longint PMAX = (64'sd1 <<< (PW - 1)) - 1;
   localparam longint PMIN = -(64'sd1 <<< (PW - 1));
   localparam logic [DW-1:0] DMAX = '1;

   typedef struct packed {
      logic                 start_req;
      logic signed [QW-1:0] qw, qx, qy, qz;
      logic signed [PW-1:0] tx, ty, tz;
   } pose_type;

   typedef struct packed {
      logic signed [QW-1:0] rx, ry, rz, rw;
      logic signed [PW-1:0] px, py, pz;
      logic [31:0]          seq;
      logic [DW-1:0]        plen;
   } inv_pose_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   pose_type drv = '0;
   logic signed [QW-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_rot_w;
   logic signed [PW-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [31:0] rsp_seq_index;
   logic [DW-1:0] rsp_path_length;

   pose_type pending_poses[$];
   inv_pose_type expected_poses[$];
   int errors = 0;
   bit stim_done = 0;

   // tracked trajectory state
   longint last_pos[3];
   bit have_last = 0;
   logic [31:0] pose_count = '0;
   logic [DW-1:0] dist_total = '0;

   pose_invert_path_length_unit i_dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_start_req(drv.start_req), .req_quat_w(drv.qw), .req_quat_x(drv.qx),
      .req_quat_y(drv.qy), .req_quat_z(drv.qz), .req_trans_x(drv.tx),
      .req_trans_y(drv.ty), .req_trans_z(drv.tz),
      .rsp_valid, .rsp_stall, .rsp_rot_x, .rsp_rot_y, .rsp_rot_z, .rsp_rot_w,
      .rsp_pos_x, .rsp_pos_y, .rsp_pos_z, .rsp_seq_index, .rsp_path_length
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // floor((x + half) / 2^k), arithmetic shift is floor
   function automatic longint rnd_shift(longint x);
      return (x + (64'sd1 <<< (QFRAC - 1))) >>> QFRAC;
   endfunction

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 50; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic inv_pose_type invert_pose(pose_type p);
      inv_pose_type o;
      longint w, u[3], v[3], t[3], q[3];
      logic [127:0] sq;
      logic [63:0] seg, d;
      w = longint'(p.qw);
      u[0] = clampv(-longint'(p.qx), QMIN, QMAX);
      u[1] = clampv(-longint'(p.qy), QMIN, QMAX);
      u[2] = clampv(-longint'(p.qz), QMIN, QMAX);
      v[0] = -longint'(p.tx);
      v[1] = -longint'(p.ty);
      v[2] = -longint'(p.tz);
      if (p.start_req) begin
         pose_count = '0;
         dist_total = '0;
         have_last = 0;
      end
      t[0] = rnd_shift(2 * (u[1] * v[2] - u[2] * v[1]));
      t[1] = rnd_shift(2 * (u[2] * v[0] - u[0] * v[2]));
      t[2] = rnd_shift(2 * (u[0] * v[1] - u[1] * v[0]));
      q[0] = w * t[0] + (u[1] * t[2] - u[2] * t[1]);
      q[1] = w * t[1] + (u[2] * t[0] - u[0] * t[2]);
      q[2] = w * t[2] + (u[0] * t[1] - u[1] * t[0]);
      for (int i = 0; i < 3; i++) q[i] = clampv(v[i] + rnd_shift(q[i]), PMIN, PMAX);
      if (have_last) begin
         sq = '0;
         for (int i = 0; i < 3; i++) begin
            d = q[i] >= last_pos[i] ? q[i] - last_pos[i] : last_pos[i] - q[i];
            sq += {64'd0, d} * {64'd0, d};
         end
         seg = isqrt(sq);
         if (seg > 64'(DMAX - dist_total)) dist_total = DMAX;
         else dist_total = dist_total + DW'(seg);
      end
      for (int i = 0; i < 3; i++) last_pos[i] = q[i];
      o.rx = QW'(u[0]);
      o.ry = QW'(u[1]);
      o.rz = QW'(u[2]);
      o.rw = p.qw;
      o.px = PW'(q[0]);
      o.py = PW'(q[1]);
      o.pz = PW'(q[2]);
      o.seq = pose_count;
      o.plen = dist_total;
      have_last = 1;
      if (pose_count != '1) pose_count++;
      return o;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 70);
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_poses = {expected_poses, invert_pose(drv)};
            req_gap = gap_len();
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0 || pending_poses.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_valid <= 0;
            end else begin
               drv <= pending_poses.pop_front();
               req_valid <= 1;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      inv_pose_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               $error("unexpected result word");
               errors++;
            end else begin
               e = expected_poses.pop_front();
               if (rsp_rot_x !== e.rx) begin
                  $error("rot_x exp %0d got %0d", e.rx, rsp_rot_x); errors++;
               end
               if (rsp_rot_y !== e.ry) begin
                  $error("rot_y exp %0d got %0d", e.ry, rsp_rot_y); errors++;
               end
               if (rsp_rot_z !== e.rz) begin
                  $error("rot_z exp %0d got %0d", e.rz, rsp_rot_z); errors++;
               end
               if (rsp_rot_w !== e.rw) begin
                  $error("rot_w exp %0d got %0d", e.rw, rsp_rot_w); errors++;
               end
               if (rsp_pos_x !== e.px) begin
                  $error("pos_x exp %0d got %0d", e.px, rsp_pos_x); errors++;
               end
               if (rsp_pos_y !== e.py) begin
                  $error("pos_y exp %0d got %0d", e.py, rsp_pos_y); errors++;
               end
               if (rsp_pos_z !== e.pz) begin
                  $error("pos_z exp %0d got %0d", e.pz, rsp_pos_z); errors++;
               end
               if (rsp_seq_index !== e.seq) begin
                  $error("seq_index exp %0d got %0d", e.seq, rsp_seq_index); errors++;
               end
               if (rsp_path_length !== e.plen) begin
                  $error("path_length exp %0d got %0d", e.plen, rsp_path_length); errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1;
         end else begin
            rsp_gap = gap_len();
            rsp_stall <= 0;
         end
      end
   end

   function automatic logic signed [QW-1:0] rand_q();
      case ($urandom_range(0, 5))
         0: return QW'(QMIN);
         1: return QW'(QMAX);
         2: return '0;
         default: return QW'($urandom_range(0, 32767) - 16384);
      endcase
   endfunction

   function automatic logic signed [PW-1:0] rand_t();
      case ($urandom_range(0, 9))
         0: return PW'(PMIN);
         1: return PW'(PMAX);
         2: return '0;
         3: return $urandom();
         default: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      endcase
   endfunction

   function automatic pose_type mk(bit s, longint qw, longint qx, longint qy, longint qz,
                                   longint tx, longint ty, longint tz);
      pose_type p;
      p.start_req = s;
      p.qw = QW'(qw); p.qx = QW'(qx); p.qy = QW'(qy); p.qz = QW'(qz);
      p.tx = PW'(tx); p.ty = PW'(ty); p.tz = PW'(tz);
      return p;
   endfunction

   // stimulus
   initial begin
      pose_type p;
      // first pose after reset without start, then unit rotations
      pending_poses = {pending_poses, mk(0, 16384, 0, 0, 0, 65536, -65536, 0)};
      pending_poses = {pending_poses, mk(0, 16384, 0, 0, 0, 131072, 0, 0)};
      pending_poses = {pending_poses, mk(0, 0, 16384, 0, 0, 0, 65536, 0)};
      pending_poses = {pending_poses, mk(0, 11585, 0, 11585, 0, 65536, 65536, 65536)};
      pending_poses = {pending_poses, mk(1, 0, 0, 0, 16384, 12345, -999, 7)};
      // most negative components, saturating negation
      pending_poses = {pending_poses, mk(0, QMIN, QMIN, QMIN, QMIN, PMAX, PMIN, PMAX)};
      pending_poses = {pending_poses, mk(0, QMAX, QMAX, QMAX, QMAX, PMIN, PMAX, PMIN)};
      pending_poses = {pending_poses, mk(0, QMAX, QMIN, QMAX, QMIN, PMIN, PMIN, PMIN)};
      pending_poses = {pending_poses, mk(0, QMIN, 0, 0, 0, PMAX, PMAX, PMAX)};
      pending_poses = {pending_poses, mk(0, 0, 0, 0, 0, 0, 0, 0)};
      pending_poses = {pending_poses, mk(0, -1, -1, -1, -1, -1, -1, -1)};
      pending_poses = {pending_poses, mk(1, 16384, 0, 0, 0, PMIN, PMIN, PMIN)};
      pending_poses = {pending_poses, mk(0, 16384, 0, 0, 0, PMAX, PMAX, PMAX)};
      pending_poses = {pending_poses, mk(1, 16384, 0, 0, 0, 0, 0, 0)};
      for (int i = 0; i < 850; i++) begin
         p.start_req = ($urandom_range(0, 19) == 0);
         p.qw = rand_q(); p.qx = rand_q(); p.qy = rand_q(); p.qz = rand_q();
         p.tx = rand_t(); p.ty = rand_t(); p.tz = rand_t();
         pending_poses = {pending_poses, p};
      end
      repeat (9) @(posedge clock);
      reset <= 0;
      wait (pending_poses.size() == 0 && !req_valid && expected_poses.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_poses.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #10000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
